// ===== design/scld_pkg.sv =====
// Shared types, character constants and helpers of the serial command line decoder.
package scld_pkg;

	localparam int LINE_BYTES_DEF = 64;

	localparam logic [4:0] REC_MAX_SECONDS = 5'd30;
	localparam logic [7:0] REC_SATURATE    = 8'd255;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_COLON = ":";
	localparam logic [7:0] CH_EQ    = "=";
	localparam logic [7:0] CH_A     = "A";
	localparam logic [7:0] CH_B     = "B";
	localparam logic [7:0] CH_0     = "0";
	localparam logic [7:0] CH_1     = "1";
	localparam logic [7:0] CH_9     = "9";

	localparam logic [31:0] TXT_PING = "PING";
	localparam logic [31:0] TXT_SENS = "SENS";
	localparam logic [31:0] TXT_AMB  = "AMB:";
	localparam logic [31:0] TXT_MEL  = "MEL:";
	localparam logic [31:0] TXT_REC  = "REC:";
	localparam logic [31:0] TXT_FFTP = "FFTP";
	localparam logic [31:0] TXT_ROBE = "ROBE";

	typedef enum logic [3:0] {
		ACT_NONE       = 4'd0,
		ACT_PING       = 4'd1,
		ACT_SENS_CHG   = 4'd2,
		ACT_SENS_SAME  = 4'd3,
		ACT_AMB_CHG    = 4'd4,
		ACT_AMB_SAME   = 4'd5,
		ACT_MEL_CHG    = 4'd6,
		ACT_MEL_SAME   = 4'd7,
		ACT_REC        = 4'd8,
		ACT_PROBE      = 4'd9,
		ACT_UNKNOWN    = 4'd10
	} action_t;

	// what the parser knows about the line once every character has gone past
	typedef struct packed {
		logic       empty;
		logic       ping;
		logic       sens;
		logic       sens_k;
		logic       sens_v;
		logic       amb;
		logic       mel;
		logic       am_v;
		logic       rec;
		logic [4:0] rec_val;
		logic       probe;
	} parse_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

	// character p of a four-character literal, first character in the top byte
	function automatic logic [7:0] byte4(input logic [31:0] s, input logic [1:0] p);
		return s[8*(3-int'(p)) +: 8];
	endfunction

endpackage

// ===== design/scld_line_mem.sv =====
// Line store: single write port, single registered read port.
module scld_line_mem #(
	parameter int DEPTH = scld_pkg::LINE_BYTES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/scld_parser.sv =====
// Streaming line parser: trims, matches the command forms and reads the REC number.
module scld_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clear,
	input  logic           ch_valid,
	input  logic [7:0]     ch,
	output scld_pkg::parse_t result
);

	typedef enum logic [1:0] {
		RP_WS,
		RP_DIG,
		RP_DONE
	} rec_phase_t;

	logic       started_q, stop_q;
	logic [3:0] pos_q;
	logic       ping_q, sens_q, amb_q, mel_q, probe_q, recp_q;
	logic       sens_k_q, sens_v_q, am_v_q;
	rec_phase_t rphase_q;
	logic       neg_q, digs_q;
	logic [7:0] rval_q;

	logic        ws, bitc, digit, active, rec_live;
	logic [3:0]  p;
	logic        ping_n, sens_n, amb_n, mel_n, probe_n, recp_n;
	logic [11:0] acc;

	always_comb begin
		ws     = scld_pkg::is_ws(ch);
		bitc   = (ch == scld_pkg::CH_0) || (ch == scld_pkg::CH_1);
		digit  = (ch >= scld_pkg::CH_0) && (ch <= scld_pkg::CH_9);
		active = ch_valid && !stop_q && (ch != scld_pkg::CH_NUL) && (started_q || !ws);
		p      = pos_q;

		// fixed forms: literal characters, then nothing but whitespace
		if (p < 4'd4) begin
			ping_n = ping_q && (ch == scld_pkg::byte4(scld_pkg::TXT_PING, p[1:0]));
		end else begin
			ping_n = ping_q && ws;
		end

		if (p < 4'd4) begin
			sens_n = sens_q && (ch == scld_pkg::byte4(scld_pkg::TXT_SENS, p[1:0]));
		end else if (p == 4'd4) begin
			sens_n = sens_q && (ch == scld_pkg::CH_COLON);
		end else if (p == 4'd5) begin
			sens_n = sens_q && ((ch == scld_pkg::CH_A) || (ch == scld_pkg::CH_B));
		end else if (p == 4'd6) begin
			sens_n = sens_q && (ch == scld_pkg::CH_EQ);
		end else if (p == 4'd7) begin
			sens_n = sens_q && bitc;
		end else begin
			sens_n = sens_q && ws;
		end

		if (p < 4'd4) begin
			amb_n = amb_q && (ch == scld_pkg::byte4(scld_pkg::TXT_AMB, p[1:0]));
			mel_n = mel_q && (ch == scld_pkg::byte4(scld_pkg::TXT_MEL, p[1:0]));
		end else if (p == 4'd4) begin
			amb_n = amb_q && bitc;
			mel_n = mel_q && bitc;
		end else begin
			amb_n = amb_q && ws;
			mel_n = mel_q && ws;
		end

		if (p < 4'd4) begin
			probe_n = probe_q && (ch == scld_pkg::byte4(scld_pkg::TXT_FFTP, p[1:0]));
		end else if (p < 4'd8) begin
			probe_n = probe_q && (ch == scld_pkg::byte4(scld_pkg::TXT_ROBE, p[1:0]));
		end else begin
			probe_n = probe_q && ws;
		end

		if (p < 4'd4) begin
			recp_n = recp_q && (ch == scld_pkg::byte4(scld_pkg::TXT_REC, p[1:0]));
		end else begin
			recp_n = recp_q;
		end

		rec_live = recp_q && (p >= 4'd4);
		acc      = 12'(rval_q) * 12'd10 + 12'(ch[3:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			stop_q    <= 1'b0;
			pos_q     <= '0;
			ping_q    <= 1'b1;
			sens_q    <= 1'b1;
			amb_q     <= 1'b1;
			mel_q     <= 1'b1;
			probe_q   <= 1'b1;
			recp_q    <= 1'b1;
			sens_k_q  <= 1'b0;
			sens_v_q  <= 1'b0;
			am_v_q    <= 1'b0;
			rphase_q  <= RP_WS;
			neg_q     <= 1'b0;
			digs_q    <= 1'b0;
			rval_q    <= '0;
		end else if (clear) begin
			started_q <= 1'b0;
			stop_q    <= 1'b0;
			pos_q     <= '0;
			ping_q    <= 1'b1;
			sens_q    <= 1'b1;
			amb_q     <= 1'b1;
			mel_q     <= 1'b1;
			probe_q   <= 1'b1;
			recp_q    <= 1'b1;
			rphase_q  <= RP_WS;
			neg_q     <= 1'b0;
			digs_q    <= 1'b0;
			rval_q    <= '0;
		end else begin
			if (ch_valid && !stop_q && ch == scld_pkg::CH_NUL) begin
				stop_q <= 1'b1;
			end
			if (active) begin
				started_q <= 1'b1;
				pos_q     <= (pos_q == 4'hF) ? pos_q : pos_q + 4'd1;
				ping_q    <= ping_n;
				sens_q    <= sens_n;
				amb_q     <= amb_n;
				mel_q     <= mel_n;
				probe_q   <= probe_n;
				recp_q    <= recp_n;
				if (p == 4'd5) begin
					sens_k_q <= (ch == scld_pkg::CH_B);
				end
				if (p == 4'd7) begin
					sens_v_q <= ch[0];
				end
				if (p == 4'd4) begin
					am_v_q <= ch[0];
				end
				if (rec_live) begin
					case (rphase_q)
						RP_WS: begin
							if (ws) begin
								rphase_q <= RP_WS;
							end else if (ch == scld_pkg::CH_PLUS || ch == scld_pkg::CH_MINUS) begin
								neg_q    <= (ch == scld_pkg::CH_MINUS);
								rphase_q <= RP_DIG;
							end else if (digit) begin
								digs_q   <= 1'b1;
								rval_q   <= 8'(ch[3:0]);
								rphase_q <= RP_DIG;
							end else begin
								rphase_q <= RP_DONE;
							end
						end
						RP_DIG: begin
							if (digit) begin
								digs_q <= 1'b1;
								rval_q <= (acc > 12'(scld_pkg::REC_SATURATE)) ?
									scld_pkg::REC_SATURATE : acc[7:0];
							end else begin
								rphase_q <= RP_DONE;
							end
						end
						default: begin
							rphase_q <= RP_DONE;
						end
					endcase
				end
			end
		end
	end

	always_comb begin
		result.empty   = !started_q;
		result.ping    = ping_q && (pos_q >= 4'd4);
		result.sens    = sens_q && (pos_q >= 4'd8);
		result.sens_k  = sens_k_q;
		result.sens_v  = sens_v_q;
		result.amb     = amb_q && (pos_q >= 4'd5);
		result.mel     = mel_q && (pos_q >= 4'd5);
		result.am_v    = am_v_q;
		result.rec     = recp_q && (pos_q >= 4'd4) && digs_q && !neg_q
			&& (rval_q != 8'd0) && (rval_q <= 8'(scld_pkg::REC_MAX_SECONDS));
		result.rec_val = rval_q[4:0];
		result.probe   = probe_q && (pos_q >= 4'd8);
	end

endmodule

// ===== design/serial_command_line_decoder.sv =====
// Top level: byte gathering, line scan sequencer, setting flags and result register.
//
//  channel   signals                                   handshake
//  input     command, rx_byte, sensor_index            start && !busy
//  result    action ... mel_on                         done, one cycle, no stall
//
// A take-pending word or a byte that does not end a line gives its result in the
// next cycle. A line-ending byte starts a scan of the line store, one character a
// cycle through its read port; the result is registered in the finish state after
// drain, and busy stays high meanwhile. Reset clears the line length, pending,
// ambient and mel flags and sets both sensor enables; the line store is not cleared.
module serial_command_line_decoder #(
	parameter int LINE_BYTES = scld_pkg::LINE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       command,
	input  logic [7:0] rx_byte,
	input  logic       sensor_index,
	output logic       done,
	output logic [3:0] action,
	output logic       status_resend,
	output logic       target_sensor,
	output logic       requested_value,
	output logic [4:0] record_seconds,
	output logic       pending_taken,
	output logic       pending_value,
	output logic       sensor_a_on,
	output logic       sensor_b_on,
	output logic       ambient_on,
	output logic       mel_on
);

	localparam int AW = $clog2(LINE_BYTES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     len_q, scan_len_q, rd_ptr_q;
	logic              rd_valid_s1;
	logic [1:0]        en_q, pend_q;
	logic              amb_q, mel_q;
	logic              done_q, resend_q, tgt_q, reqv_q, taken_q, pval_q;
	scld_pkg::action_t action_q;
	logic [4:0]        rec_q;

	logic              accept, wr_en, rd_en, line_end;
	logic [AW-1:0]     len_nxt;
	logic [7:0]        rd_data;
	scld_pkg::parse_t  pr;
	scld_pkg::action_t fin_act;
	logic              fin_resend;

	assign accept   = start && (state_q == ST_IDLE);
	assign wr_en    = accept && !command;
	assign len_nxt  = len_q + AW'(1);
	assign line_end = (rx_byte == scld_pkg::CH_LF) || (len_nxt == AW'(LINE_BYTES - 1));
	assign rd_en    = (state_q == ST_SCAN);

	scld_line_mem #(
		.DEPTH(LINE_BYTES),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(len_q),
		.wr_data(rx_byte),
		.rd_en  (rd_en),
		.rd_addr(rd_ptr_q),
		.rd_data(rd_data)
	);

	scld_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (state_q == ST_IDLE),
		.ch_valid(rd_valid_s1),
		.ch      (rd_data),
		.result  (pr)
	);

	// command priority follows the order the forms are tried in
	always_comb begin
		fin_act    = scld_pkg::ACT_UNKNOWN;
		fin_resend = 1'b0;
		if (pr.empty) begin
			fin_act = scld_pkg::ACT_NONE;
		end else if (pr.ping) begin
			fin_act    = scld_pkg::ACT_PING;
			fin_resend = 1'b1;
		end else if (pr.sens) begin
			fin_resend = (en_q[pr.sens_k] != pr.sens_v);
			fin_act    = fin_resend ? scld_pkg::ACT_SENS_CHG : scld_pkg::ACT_SENS_SAME;
		end else if (pr.amb) begin
			fin_resend = (amb_q != pr.am_v);
			fin_act    = fin_resend ? scld_pkg::ACT_AMB_CHG : scld_pkg::ACT_AMB_SAME;
		end else if (pr.mel) begin
			fin_resend = (mel_q != pr.am_v);
			fin_act    = fin_resend ? scld_pkg::ACT_MEL_CHG : scld_pkg::ACT_MEL_SAME;
		end else if (pr.rec) begin
			fin_act = scld_pkg::ACT_REC;
		end else if (pr.probe) begin
			fin_act = scld_pkg::ACT_PROBE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			scan_len_q  <= '0;
			rd_ptr_q    <= '0;
			rd_valid_s1 <= 1'b0;
			en_q        <= 2'b11;
			pend_q      <= 2'b00;
			amb_q       <= 1'b0;
			mel_q       <= 1'b0;
			done_q      <= 1'b0;
			action_q    <= scld_pkg::ACT_NONE;
			resend_q    <= 1'b0;
			tgt_q       <= 1'b0;
			reqv_q      <= 1'b0;
			rec_q       <= '0;
			taken_q     <= 1'b0;
			pval_q      <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			rd_valid_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						action_q <= scld_pkg::ACT_NONE;
						resend_q <= 1'b0;
						tgt_q    <= 1'b0;
						reqv_q   <= 1'b0;
						rec_q    <= '0;
						taken_q  <= 1'b0;
						pval_q   <= 1'b0;
						if (command) begin
							done_q <= 1'b1;
							if (pend_q[sensor_index]) begin
								taken_q                <= 1'b1;
								pval_q                 <= en_q[sensor_index];
								pend_q[sensor_index]   <= 1'b0;
							end
						end else if (line_end) begin
							scan_len_q <= len_nxt;
							len_q      <= '0;
							rd_ptr_q   <= '0;
							state_q    <= ST_SCAN;
						end else begin
							len_q  <= len_nxt;
							done_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					rd_ptr_q <= rd_ptr_q + AW'(1);
					if (rd_ptr_q == scan_len_q - AW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last character is in the parser this cycle
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					done_q   <= 1'b1;
					action_q <= fin_act;
					resend_q <= fin_resend;
					tgt_q    <= pr.sens && !pr.ping && pr.sens_k;
					reqv_q   <= (pr.sens && !pr.ping) ? pr.sens_v :
						((pr.amb || pr.mel) && !pr.ping && !pr.sens) ? pr.am_v : 1'b0;
					rec_q    <= (fin_act == scld_pkg::ACT_REC) ? pr.rec_val : 5'd0;
					if (fin_act == scld_pkg::ACT_SENS_CHG) begin
						en_q[pr.sens_k]   <= pr.sens_v;
						pend_q[pr.sens_k] <= 1'b1;
					end
					if (fin_act == scld_pkg::ACT_AMB_CHG) begin
						amb_q <= pr.am_v;
					end
					if (fin_act == scld_pkg::ACT_MEL_CHG) begin
						mel_q <= pr.am_v;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign action          = action_q;
	assign status_resend   = resend_q;
	assign target_sensor   = tgt_q;
	assign requested_value = reqv_q;
	assign record_seconds  = rec_q;
	assign pending_taken   = taken_q;
	assign pending_value   = pval_q;
	assign sensor_a_on     = en_q[0];
	assign sensor_b_on     = en_q[1];
	assign ambient_on      = amb_q;
	assign mel_on          = mel_q;

endmodule

// ===== design/scld_checker.sv =====
// Port-level checks on the serial command line decoder, bound to the top level.
module scld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       command,
	input logic       done,
	input logic [3:0] action,
	input logic       status_resend,
	input logic [4:0] record_seconds,
	input logic       pending_taken
);

	// a take-pending word always answers in the next cycle
	a_take_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command |=> done && !busy)
		else $error("take-pending word gave no result in the next cycle");

	// busy rises only after a started byte, never after a take-pending word
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && !$past(command))
		else $error("busy rose without an accepted byte");

	a_resend_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_resend |-> action == scld_pkg::ACT_PING
			|| action == scld_pkg::ACT_SENS_CHG || action == scld_pkg::ACT_AMB_CHG
			|| action == scld_pkg::ACT_MEL_CHG)
		else $error("status resend on an action that changes nothing");

	a_rec_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && record_seconds != 5'd0 |-> action == scld_pkg::ACT_REC)
		else $error("record seconds without a record action");

	a_taken_none: assert property (@(posedge clk) disable iff (!arst_n)
		done && pending_taken |-> action == scld_pkg::ACT_NONE)
		else $error("pending request taken together with a line action");

endmodule

bind serial_command_line_decoder scld_checker u_scld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.command       (command),
	.done          (done),
	.action        (action),
	.status_resend (status_resend),
	.record_seconds(record_seconds),
	.pending_taken (pending_taken)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the serial command line decoder: directed lines, then random traffic.
`timescale 1ns / 100ps

module tb;

	localparam int CLK_PERIOD      = 2;
	localparam int LINE_BYTES      = scld_pkg::LINE_BYTES_DEF;
	localparam int RANDOM_ITEMS    = 1000;
	localparam int WATCHDOG_CYCLES = 1000;
	localparam int PRINT_LIMIT     = 40;
	localparam int DIR_ROWS        = 29;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;

	typedef enum logic [1:0] {
		ROW_LINE, // text, then newline
		ROW_LONG, // text padded with spaces to a full line, no newline
		ROW_TAKE  // take-pending word
	} row_kind_t;

	// in row text, '@' is sent as a NUL byte and '~' as 8'hFF
	typedef struct packed {
		row_kind_t         kind;
		logic              idx;
		logic              pin;
		scld_pkg::action_t act;
		logic [95:0]       txt;
	} row_t;

	typedef struct packed {
		scld_pkg::action_t action;
		logic              resend;
		logic              sensor;
		logic              value;
		logic [4:0]        seconds;
		logic              taken;
		logic              handed;
		logic              a_on;
		logic              b_on;
		logic              amb;
		logic              mel;
	} outcome_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       command;
	logic [7:0] rx_byte;
	logic       sensor_index;
	logic       done;
	logic [3:0] action;
	logic       status_resend;
	logic       target_sensor;
	logic       requested_value;
	logic [4:0] record_seconds;
	logic       pending_taken;
	logic       pending_value;
	logic       sensor_a_on;
	logic       sensor_b_on;
	logic       ambient_on;
	logic       mel_on;

	// travels with the word: typed action for the last word of a directed row
	logic              pin_en;
	scld_pkg::action_t pin_act;

	// decoder state as this testbench sees it
	logic [7:0] line_buf [LINE_BYTES];
	int         line_len;
	logic       sens_en [2];
	logic       sens_pend [2];
	logic       amb_flag;
	logic       mel_flag;

	outcome_t   outcomes_due [$];
	outcome_t   fresh;
	logic [7:0] text_q [$];
	int         items_sent;
	int         burst_left;
	int         idle_cycles;
	int         errors;

	row_t dir_rows [DIR_ROWS] = '{
		'{ROW_TAKE, 1'b0, 1'b1, scld_pkg::ACT_NONE,      ""},
		'{ROW_TAKE, 1'b1, 1'b1, scld_pkg::ACT_NONE,      ""},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_PING,      "PING"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_PING,      "\t PING \015"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_NONE,      ""},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_NONE,      " \t\013\014"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_SENS_SAME, "SENS:A=1"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_SENS_CHG,  "SENS:A=0"},
		'{ROW_TAKE, 1'b0, 1'b0, scld_pkg::ACT_NONE,      ""},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_SENS_CHG,  "SENS:B=0"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_SENS_SAME, "SENS:B=0"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_AMB_CHG,   "AMB:1"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_AMB_SAME,  "AMB:1"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_MEL_SAME,  "MEL:0"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_MEL_CHG,   "MEL:1"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_REC,       "REC:30"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_REC,       "REC: +7s"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_UNKNOWN,   "REC:31"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_UNKNOWN,   "REC:-5"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_UNKNOWN,   "REC:"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_UNKNOWN,   "REC:00099999"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_PROBE,     "FFTPROBE"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_PING,      "PING@xyz"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_UNKNOWN,   "PI@NG"},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_UNKNOWN,   "~"},
		'{ROW_LONG, 1'b0, 1'b1, scld_pkg::ACT_PING,      "PING"},
		'{ROW_LONG, 1'b0, 1'b1, scld_pkg::ACT_UNKNOWN,   "Q"},
		'{ROW_TAKE, 1'b1, 1'b0, scld_pkg::ACT_NONE,      ""},
		'{ROW_LINE, 1'b0, 1'b1, scld_pkg::ACT_UNKNOWN,   "sens:a=1"}
	};

	serial_command_line_decoder DUT (
		.clk, .arst_n, .start, .busy, .command, .rx_byte, .sensor_index, .done,
		.action, .status_resend, .target_sensor, .requested_value, .record_seconds,
		.pending_taken, .pending_value, .sensor_a_on, .sensor_b_on, .ambient_on, .mel_on
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic is_space(input logic [7:0] c);
		return c == scld_pkg::CH_SPACE || (c >= scld_pkg::CH_TAB && c <= scld_pkg::CH_CR);
	endfunction

	function automatic logic is_bit(input logic [7:0] c);
		return c == scld_pkg::CH_0 || c == scld_pkg::CH_1;
	endfunction

	function automatic logic text_starts(input int s, input int n, input string lit);
		int i;
		if (n < lit.len())
			return 1'b0;
		for (i = 0; i < lit.len(); i++)
			if (line_buf[s + i] != lit[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic text_is(input int s, input int n, input string lit);
		return n == lit.len() && text_starts(s, n, lit);
	endfunction

	// decode the gathered line and update the setting flags
	function automatic outcome_t line_outcome();
		outcome_t o;
		int stop, s, n, j, last, val, digits;
		logic neg, k, v;
		o = '0;
		stop = 0;
		while (stop < line_len && line_buf[stop] != scld_pkg::CH_NUL)
			stop++;
		s = 0;
		while (s < stop && is_space(line_buf[s]))
			s++;
		while (stop > s && is_space(line_buf[stop - 1]))
			stop--;
		n = stop - s;
		if (n == 0) begin
			o.action = scld_pkg::ACT_NONE;
		end else if (text_is(s, n, "PING")) begin
			o.action = scld_pkg::ACT_PING;
			o.resend = 1'b1;
		end else if (n == 8 && text_starts(s, n, "SENS:")
				&& (line_buf[s + 5] == scld_pkg::CH_A || line_buf[s + 5] == scld_pkg::CH_B)
				&& line_buf[s + 6] == scld_pkg::CH_EQ && is_bit(line_buf[s + 7])) begin
			k = line_buf[s + 5] == scld_pkg::CH_B;
			v = line_buf[s + 7] == scld_pkg::CH_1;
			o.sensor = k;
			o.value = v;
			if (sens_en[k] != v) begin
				sens_en[k] = v;
				sens_pend[k] = 1'b1;
				o.action = scld_pkg::ACT_SENS_CHG;
				o.resend = 1'b1;
			end else begin
				o.action = scld_pkg::ACT_SENS_SAME;
			end
		end else if (n == 5 && text_starts(s, n, "AMB:") && is_bit(line_buf[s + 4])) begin
			v = line_buf[s + 4] == scld_pkg::CH_1;
			o.value = v;
			if (amb_flag != v) begin
				amb_flag = v;
				o.action = scld_pkg::ACT_AMB_CHG;
				o.resend = 1'b1;
			end else begin
				o.action = scld_pkg::ACT_AMB_SAME;
			end
		end else if (n == 5 && text_starts(s, n, "MEL:") && is_bit(line_buf[s + 4])) begin
			v = line_buf[s + 4] == scld_pkg::CH_1;
			o.value = v;
			if (mel_flag != v) begin
				mel_flag = v;
				o.action = scld_pkg::ACT_MEL_CHG;
				o.resend = 1'b1;
			end else begin
				o.action = scld_pkg::ACT_MEL_SAME;
			end
		end else begin
			if (text_starts(s, n, "REC:")) begin
				j = s + 4;
				last = s + n;
				while (j < last && is_space(line_buf[j]))
					j++;
				neg = 1'b0;
				if (j < last && (line_buf[j] == scld_pkg::CH_PLUS
						|| line_buf[j] == scld_pkg::CH_MINUS)) begin
					neg = line_buf[j] == scld_pkg::CH_MINUS;
					j++;
				end
				val = 0;
				digits = 0;
				while (j < last && line_buf[j] >= scld_pkg::CH_0
						&& line_buf[j] <= scld_pkg::CH_9) begin
					val = val * 10 + int'(line_buf[j]) - int'(scld_pkg::CH_0);
					if (val > int'(scld_pkg::REC_SATURATE))
						val = int'(scld_pkg::REC_SATURATE);
					digits++;
					j++;
				end
				if (digits > 0 && !neg && val >= 1 && val <= int'(scld_pkg::REC_MAX_SECONDS))
				begin
					o.action = scld_pkg::ACT_REC;
					o.seconds = val[4:0];
				end
			end
			if (o.action != scld_pkg::ACT_REC)
				o.action = text_is(s, n, "FFTPROBE") ? scld_pkg::ACT_PROBE :
					scld_pkg::ACT_UNKNOWN;
		end
		return o;
	endfunction

	function automatic outcome_t word_outcome(input logic cmd, input logic [7:0] c,
			input logic k);
		outcome_t o;
		o = '0;
		if (cmd) begin
			if (sens_pend[k]) begin
				o.taken = 1'b1;
				o.handed = sens_en[k];
				sens_pend[k] = 1'b0;
			end
		end else begin
			line_buf[line_len] = c;
			line_len++;
			if (c == scld_pkg::CH_LF || line_len >= LINE_BYTES - 1) begin
				o = line_outcome();
				line_len = 0;
			end
		end
		o.a_on = sens_en[0];
		o.b_on = sens_en[1];
		o.amb = amb_flag;
		o.mel = mel_flag;
		return o;
	endfunction

	task automatic flag_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want_v);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want_v);
	endtask

	task automatic check_outcome(input outcome_t w);
		if (action !== w.action)
			flag_mismatch("action", 8'(action), 8'(w.action));
		if (status_resend !== w.resend)
			flag_mismatch("status_resend", 8'(status_resend), 8'(w.resend));
		if (target_sensor !== w.sensor)
			flag_mismatch("target_sensor", 8'(target_sensor), 8'(w.sensor));
		if (requested_value !== w.value)
			flag_mismatch("requested_value", 8'(requested_value), 8'(w.value));
		if (record_seconds !== w.seconds)
			flag_mismatch("record_seconds", 8'(record_seconds), 8'(w.seconds));
		if (pending_taken !== w.taken)
			flag_mismatch("pending_taken", 8'(pending_taken), 8'(w.taken));
		if (pending_value !== w.handed)
			flag_mismatch("pending_value", 8'(pending_value), 8'(w.handed));
		if (sensor_a_on !== w.a_on)
			flag_mismatch("sensor_a_on", 8'(sensor_a_on), 8'(w.a_on));
		if (sensor_b_on !== w.b_on)
			flag_mismatch("sensor_b_on", 8'(sensor_b_on), 8'(w.b_on));
		if (ambient_on !== w.amb)
			flag_mismatch("ambient_on", 8'(ambient_on), 8'(w.amb));
		if (mel_on !== w.mel)
			flag_mismatch("mel_on", 8'(mel_on), 8'(w.mel));
	endtask

	// results are checked before the word accepted at the same edge is queued
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if (done) begin
				if (outcomes_due.size() == 0)
					flag_mismatch("result with nothing outstanding, action", 8'(action),
						8'h00);
				else
					check_outcome(outcomes_due.pop_front());
			end
			if (start && !busy) begin
				fresh = word_outcome(command, rx_byte, sensor_index);
				if (pin_en)
					fresh.action = pin_act;
				outcomes_due.push_back(fresh);
			end
			if (done || (start && !busy)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_CYCLES) begin
					$display("tb: errors");
					$finish;
				end
			end
		end
	end

	// sender works in bursts with random gaps between them
	task automatic send_word(input logic cmd, input logic [7:0] c, input logic k,
			input logic pin, input scld_pkg::action_t act);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk) start <= 1'b0;
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(20, 80)) @(negedge clk);
				else
					repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		command <= cmd;
		rx_byte <= c;
		sensor_index <= k;
		pin_en <= pin;
		pin_act <= act;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	task automatic send_text(input logic mix_takes, input logic pin,
			input scld_pkg::action_t act);
		int i;
		for (i = 0; i < text_q.size(); i++) begin
			if (mix_takes && $urandom_range(0, 24) == 0)
				send_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
					scld_pkg::ACT_NONE);
			send_word(1'b0, text_q[i], 1'($urandom_range(0, 1)),
				pin && i == text_q.size() - 1, act);
		end
	endtask

	function automatic void add_text(input string t);
		int i;
		for (i = 0; i < t.len(); i++)
			text_q.push_back(t[i]);
	endfunction

	function automatic logic [7:0] ws_char();
		case ($urandom_range(0, 4))
			0: return scld_pkg::CH_TAB;
			1: return CH_VT;
			2: return CH_FF;
			3: return scld_pkg::CH_CR;
			default: return scld_pkg::CH_SPACE;
		endcase
	endfunction

	function automatic string rec_text();
		string t;
		int r;
		t = "REC:";
		if ($urandom_range(0, 3) == 0)
			t = {t, $urandom_range(0, 1) ? " " : "\t"};
		case ($urandom_range(0, 5))
			0: t = {t, "+"};
			1: t = {t, "-"};
			default: ;
		endcase
		r = $urandom_range(0, 9);
		if (r == 0)
			;
		else if (r < 7)
			t = {t, $sformatf("%0d", $urandom_range(0, 35))};
		else if (r < 8)
			t = {t, $sformatf("00%0d", $urandom_range(0, 40))};
		else
			t = {t, $sformatf("%0d", $urandom_range(36, 100000))};
		if ($urandom_range(0, 4) == 0)
			t = {t, $urandom_range(0, 1) ? "s" : $sformatf(" x%0d", $urandom_range(0, 9))};
		return t;
	endfunction

	// mostly well-formed commands with random padding; some corrupted, junk, empty or long lines
	task automatic build_random_line();
		int pick, first;
		logic long_line;
		string body;
		text_q.delete();
		pick = $urandom_range(0, 99);
		long_line = $urandom_range(0, 15) == 0;
		repeat ($urandom_range(0, 2)) text_q.push_back(ws_char());
		first = text_q.size();
		if (pick < 70) begin
			if (pick < 12)
				body = "PING";
			else if (pick < 30)
				body = $sformatf("SENS:%s=%0d", $urandom_range(0, 1) ? "B" : "A",
					$urandom_range(0, 1));
			else if (pick < 40)
				body = $sformatf("AMB:%0d", $urandom_range(0, 1));
			else if (pick < 50)
				body = $sformatf("MEL:%0d", $urandom_range(0, 1));
			else if (pick < 64)
				body = rec_text();
			else
				body = "FFTPROBE";
			add_text(body);
			if ($urandom_range(0, 6) == 0)
				text_q[first + $urandom_range(0, body.len() - 1)] =
					8'($urandom_range(0, 255));
			if ($urandom_range(0, 12) == 0) begin
				text_q.push_back(scld_pkg::CH_NUL);
				repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
			end
		end else if (pick < 86) begin
			repeat ($urandom_range(0, 12)) text_q.push_back(8'($urandom_range(0, 255)));
		end
		repeat ($urandom_range(0, 2)) text_q.push_back(ws_char());
		if (long_line) begin
			if ($urandom_range(0, 2) != 0) begin
				while (text_q.size() < LINE_BYTES - 1)
					text_q.push_back(ws_char());
			end else begin
				while (text_q.size() < LINE_BYTES - 1)
					text_q.push_back(8'($urandom_range(33, 126)));
			end
		end else begin
			text_q.push_back(scld_pkg::CH_LF);
		end
	endtask

	initial begin
		int i, b, random_end;
		logic [7:0] c;
		arst_n = 1'b0;
		start = 1'b0;
		command = 1'b0;
		rx_byte = 8'h00;
		sensor_index = 1'b0;
		pin_en = 1'b0;
		pin_act = scld_pkg::ACT_NONE;
		line_len = 0;
		sens_en[0] = 1'b1;
		sens_en[1] = 1'b1;
		sens_pend[0] = 1'b0;
		sens_pend[1] = 1'b0;
		amb_flag = 1'b0;
		mel_flag = 1'b0;
		items_sent = 0;
		burst_left = 0;
		errors = 0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_TAKE) begin
				send_word(1'b1, 8'($urandom_range(0, 255)), dir_rows[i].idx, dir_rows[i].pin,
					dir_rows[i].act);
			end else begin
				text_q.delete();
				for (b = 11; b >= 0; b--) begin
					c = dir_rows[i].txt[8 * b +: 8];
					if (c != scld_pkg::CH_NUL)
						text_q.push_back(c == "@" ? scld_pkg::CH_NUL : (c == "~" ? 8'hFF : c));
				end
				if (dir_rows[i].kind == ROW_LINE)
					text_q.push_back(scld_pkg::CH_LF);
				else
					while (text_q.size() < LINE_BYTES - 1)
						text_q.push_back(scld_pkg::CH_SPACE);
				send_text(1'b0, dir_rows[i].pin, dir_rows[i].act);
			end
		end

		random_end = items_sent + RANDOM_ITEMS;
		while (items_sent < random_end) begin
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 3))
					send_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
						scld_pkg::ACT_NONE);
			end else begin
				build_random_line();
				send_text(1'b1, 1'b0, scld_pkg::ACT_NONE);
			end
		end

		@(negedge clk) start <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (LINE_BYTES + 8) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/scld_pkg.sv
design/scld_line_mem.sv
design/scld_parser.sv
design/serial_command_line_decoder.sv
design/scld_checker.sv
tb/tb.sv
